// ===== rtl/core/aat_pkg.sv =====
package aat_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned ProdW    = 2 * CoordW;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned NumAxes  = 3;
  localparam int unsigned NumRegs  = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic [CfgIdxW-1:0]       cfg_idx_t;
  typedef logic [CfgDataW-1:0]      cfg_data_t;

  // Register indexes.
  localparam cfg_idx_t CfgXrowCols01 = 3'd0;
  localparam cfg_idx_t CfgXrowCols23 = 3'd1;
  localparam cfg_idx_t CfgYrowCols01 = 3'd2;
  localparam cfg_idx_t CfgYrowCols23 = 3'd3;
  localparam cfg_idx_t CfgZrowCols01 = 3'd4;
  localparam cfg_idx_t CfgZrowCols23 = 3'd5;

  // Reset values form the identity matrix.
  localparam cfg_data_t CfgResetVal [NumRegs] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000
  };

  localparam coord_t CoordMax = 32'sh7fff_ffff;
  localparam coord_t CoordMin = 32'sh8000_0000;

  // Drops the fraction bits of a full-precision sum (floor) and saturates to 32 bits.
  function automatic coord_t shift_sat(input sum_t s);
    logic [SumW-FracBits-CoordW:0] top;
    top = s[SumW-1:FracBits+CoordW-1];
    if ((top == '0) || (top == '1)) begin
      return coord_t'(s[FracBits+CoordW-1:FracBits]);
    end else if (s[SumW-1]) begin
      return CoordMin;
    end else begin
      return CoordMax;
    end
  endfunction

endpackage

// ===== rtl/core/aat_if.sv =====
interface aat_box_in_if;
  import aat_pkg::*;
  logic   valid;
  logic   ready;
  coord_t min_x;
  coord_t min_y;
  coord_t min_z;
  coord_t max_x;
  coord_t max_y;
  coord_t max_z;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface aat_box_out_if;
  import aat_pkg::*;
  logic   valid;
  logic   ready;
  coord_t out_min_x;
  coord_t out_min_y;
  coord_t out_min_z;
  coord_t out_max_x;
  coord_t out_max_y;
  coord_t out_max_z;

  modport source (output valid, out_min_x, out_min_y, out_min_z,
                  out_max_x, out_max_y, out_max_z, input ready);
  modport sink   (input valid, out_min_x, out_min_y, out_min_z,
                  out_max_x, out_max_y, out_max_z, output ready);
endinterface

interface aat_cfg_if;
  import aat_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/aabb_affine_transform.sv =====
// Transforms an axis-aligned box (min and max corners, signed Q16.16) by the
// upper three rows of a 4x4 affine matrix and returns the bounding box of the
// eight transformed corners, saturated to signed Q16.16.
//
// Channels: box_in_i takes one box per transaction, box_out_o gives one box
// per transaction, cfg_i writes one 64-bit matrix register (two Q16.16 entries).
// cfg_i is always ready; write it only while no box is in flight.
//
// From an accepted input to a valid output, the box enters the input register
// at the accepting edge, then passes the multiplier register (18 products of
// 32 by 32 bits) and the min/max register, and the add, shift and saturate go
// into the output register.
// Throughput is one box per cycle while the receiver keeps ready high.
//
// Reset clears the pipeline and loads the identity matrix.
// When the receiver stalls, the output holds and each stage fills in turn;
// box_in_i.ready drops only once all four stages hold a box.
module aabb_affine_transform (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  aat_box_in_if.sink            box_in_i,
  aat_box_out_if.source         box_out_o,
  aat_cfg_if.sink               cfg_i
);
  import aat_pkg::*;

  localparam int unsigned NumStages = 4;

  cfg_data_t cfg_q [NumRegs];
  coord_t    mat   [NumAxes][4];

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;

  coord_t lo_q [NumAxes];
  coord_t hi_q [NumAxes];
  prod_t  pa_q [NumAxes][NumAxes];
  prod_t  pb_q [NumAxes][NumAxes];
  prod_t  pmin_q [NumAxes][NumAxes];
  prod_t  pmax_q [NumAxes][NumAxes];
  coord_t omin_q [NumAxes];
  coord_t omax_q [NumAxes];

  prod_t  pa_d [NumAxes][NumAxes];
  prod_t  pb_d [NumAxes][NumAxes];
  coord_t omin_d [NumAxes];
  coord_t omax_d [NumAxes];

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        cfg_q[i] <= CfgResetVal[i];
      end
    end else if (cfg_i.valid && cfg_i.ready && (cfg_i.index < CfgIdxW'(NumRegs))) begin
      cfg_q[cfg_i.index] <= cfg_i.data;
    end
  end

  always_comb begin
    for (int r = 0; r < NumAxes; r++) begin
      mat[r][0] = coord_t'(cfg_q[2*r][CoordW-1:0]);
      mat[r][1] = coord_t'(cfg_q[2*r][CfgDataW-1:CoordW]);
      mat[r][2] = coord_t'(cfg_q[2*r+1][CoordW-1:0]);
      mat[r][3] = coord_t'(cfg_q[2*r+1][CfgDataW-1:CoordW]);
    end
  end

  // Each stage advances when it is empty or the stage after it advances.
  assign en[NumStages-1] = !valid_q[NumStages-1] || box_out_o.ready;
  for (genvar k = 0; k < NumStages - 1; k++) begin : g_en
    assign en[k] = !valid_q[k] || en[k+1];
  end
  assign box_in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= box_in_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage 0: input register.
  always_ff @(posedge clk_i) begin
    if (en[0] && box_in_i.valid) begin
      lo_q[0] <= box_in_i.min_x;
      lo_q[1] <= box_in_i.min_y;
      lo_q[2] <= box_in_i.min_z;
      hi_q[0] <= box_in_i.max_x;
      hi_q[1] <= box_in_i.max_y;
      hi_q[2] <= box_in_i.max_z;
    end
  end

  // Stage 1: one product per matrix entry and corner coordinate.
  always_comb begin
    for (int r = 0; r < NumAxes; r++) begin
      for (int c = 0; c < NumAxes; c++) begin
        pa_d[r][c] = prod_t'(mat[r][c]) * prod_t'(lo_q[c]);
        pb_d[r][c] = prod_t'(mat[r][c]) * prod_t'(hi_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1] && valid_q[0]) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
  end

  // Stage 2: the smaller and larger term of each column.
  always_ff @(posedge clk_i) begin
    if (en[2] && valid_q[1]) begin
      for (int r = 0; r < NumAxes; r++) begin
        for (int c = 0; c < NumAxes; c++) begin
          if (pa_q[r][c] < pb_q[r][c]) begin
            pmin_q[r][c] <= pa_q[r][c];
            pmax_q[r][c] <= pb_q[r][c];
          end else begin
            pmin_q[r][c] <= pb_q[r][c];
            pmax_q[r][c] <= pa_q[r][c];
          end
        end
      end
    end
  end

  // Stage 3: full-precision row sums with the translation, then floor and saturate.
  always_comb begin
    sum_t trans;
    sum_t smin;
    sum_t smax;
    for (int r = 0; r < NumAxes; r++) begin
      trans = {{(SumW-CoordW-FracBits){mat[r][3][CoordW-1]}}, mat[r][3], {FracBits{1'b0}}};
      smin  = trans;
      smax  = trans;
      for (int c = 0; c < NumAxes; c++) begin
        smin = smin + sum_t'(pmin_q[r][c]);
        smax = smax + sum_t'(pmax_q[r][c]);
      end
      omin_d[r] = shift_sat(smin);
      omax_d[r] = shift_sat(smax);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3] && valid_q[2]) begin
      omin_q <= omin_d;
      omax_q <= omax_d;
    end
  end

  assign box_out_o.valid     = valid_q[NumStages-1];
  assign box_out_o.out_min_x = omin_q[0];
  assign box_out_o.out_min_y = omin_q[1];
  assign box_out_o.out_min_z = omin_q[2];
  assign box_out_o.out_max_x = omax_q[0];
  assign box_out_o.out_max_y = omax_q[1];
  assign box_out_o.out_max_z = omax_q[2];

  // Input stalls only when every stage holds a box.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !box_in_i.ready |-> (&valid_q))
    else $error("input stalled while the pipeline has a free stage");

  // An accepted box always lands in the input register.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (box_in_i.valid && box_in_i.ready) |=> valid_q[0])
    else $error("accepted box did not enter the input register");

  // Min and max terms are ordered and the shift and saturation are monotonic.
  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_out_o.valid |-> ((box_out_o.out_min_x <= box_out_o.out_max_x) &&
                         (box_out_o.out_min_y <= box_out_o.out_max_y) &&
                         (box_out_o.out_min_z <= box_out_o.out_max_z)))
    else $error("output box has a minimum above its maximum");

endmodule
